FILE: design/ukvt_pkg.sv
// Shared constants, codes and types of the unordered key-value table.
package ukvt_pkg;

    localparam int CAPACITY  = 128;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int PTR_W     = $clog2(CAPACITY + 2);
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 8;
    localparam int ACT_W     = 2;
    localparam int STAT_W    = 2;
    localparam int OUT_IDX_W = 7;
    localparam int OUT_CNT_W = 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_MISSING = 2'd1,
        STAT_PRESENT = 2'd2,
        STAT_FULL    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

    typedef struct packed {
        t_status          status;
        logic [VAL_W-1:0] found_value;
        logic [IDX_W-1:0] found_index;
        logic [CNT_W-1:0] entry_count;
    } t_result;

endpackage

FILE: design/ukvt_if.sv
// Request and response channel interfaces of the key-value table.
interface ukvt_req_if import ukvt_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic signed [KEY_W-1:0] key;
    logic [VAL_W-1:0]        value;

    modport source (output valid, output action, output key, output value, input ready);
    modport sink   (input valid, input action, input key, input value, output ready);
endinterface

interface ukvt_rsp_if import ukvt_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [STAT_W-1:0]    status;
    logic [VAL_W-1:0]     found_value;
    logic [OUT_IDX_W-1:0] found_index;
    logic [OUT_CNT_W-1:0] entry_count;

    modport source (output valid, output status, output found_value, output found_index,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input found_value, input found_index,
                    input entry_count, output ready);
endinterface

FILE: design/ukvt_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module ukvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/ukvt_seq.sv
// Sequencer: linear search with one key comparator, append, and shift-down on remove.
module ukvt_seq import ukvt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ukvt_req_if.sink         i_req,
    output t_result          o_res,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output logic             o_ram_we,
    output logic [IDX_W-1:0] o_ram_waddr,
    output t_entry           o_ram_wdata,
    output logic [IDX_W-1:0] o_ram_raddr,
    input  t_entry           i_ram_rdata
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PTR_W-1:0] r_ptr, n_ptr;          // read address in flight
    logic [PTR_W-1:0] r_cmp_ptr, n_cmp_ptr;  // slot of the data now on the read port
    logic             r_cmp_vld, n_cmp_vld;
    t_action          r_action, n_action;
    logic [KEY_W-1:0] r_key, n_key;
    logic [VAL_W-1:0] r_value, n_value;
    t_status          r_status, n_status;
    logic [VAL_W-1:0] r_fval, n_fval;
    logic [IDX_W-1:0] r_fidx, n_fidx;

    logic             hit;
    logic             last;
    logic [PTR_W-1:0] count_ext;
    logic [PTR_W-1:0] cmp_next;
    logic [PTR_W-1:0] shift_dst;

    assign count_ext = PTR_W'(r_count);
    assign cmp_next  = r_cmp_ptr + 1'b1;
    assign shift_dst = r_cmp_ptr - 1'b1;
    assign hit       = r_cmp_vld && (i_ram_rdata.key == r_key);
    assign last      = r_cmp_vld && (cmp_next >= count_ext);

    assign o_ram_raddr = r_ptr[IDX_W-1:0];
    assign i_req.ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = '{status: r_status, found_value: r_fval,
                           found_index: r_fidx, entry_count: r_count};

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_cmp_ptr   = r_cmp_ptr;
        n_cmp_vld   = r_cmp_vld;
        n_action    = r_action;
        n_key       = r_key;
        n_value     = r_value;
        n_status    = r_status;
        n_fval      = r_fval;
        n_fidx      = r_fidx;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_count[IDX_W-1:0];
        o_ram_wdata = '{key: r_key, value: r_value};

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_action  = t_action'(i_req.action);
                    n_key     = i_req.key;
                    n_value   = i_req.value;
                    n_ptr     = '0;
                    n_cmp_vld = 1'b0;
                    n_state   = S_SEARCH;
                end
            end
            S_SEARCH: begin
                n_ptr     = r_ptr + 1'b1;
                n_cmp_ptr = r_ptr;
                n_cmp_vld = 1'b1;
                if (hit) begin
                    n_fidx  = r_cmp_ptr[IDX_W-1:0];
                    n_state = S_DONE;
                    case (r_action)
                        ACT_LOOKUP: begin
                            n_status = STAT_OK;
                            n_fval   = i_ram_rdata.value;
                        end
                        ACT_INSERT: begin
                            n_status = STAT_PRESENT;
                            n_fval   = '0;
                        end
                        ACT_REMOVE: begin
                            n_status = STAT_OK;
                            n_fval   = i_ram_rdata.value;
                            n_state  = S_SHIFT;
                        end
                        default: begin
                            n_status = STAT_MISSING;
                            n_fval   = '0;
                            n_fidx   = '0;
                        end
                    endcase
                end else if (r_count == '0 || last) begin
                    n_fval  = '0;
                    n_fidx  = '0;
                    n_state = S_DONE;
                    if (r_action == ACT_INSERT) begin
                        if (r_count >= CNT_W'(CAPACITY)) begin
                            n_status = STAT_FULL;
                        end else begin
                            o_ram_we = 1'b1;
                            n_fidx   = r_count[IDX_W-1:0];
                            n_count  = r_count + 1'b1;
                            n_status = STAT_OK;
                        end
                    end else begin
                        n_status = STAT_MISSING;
                    end
                end
            end
            S_SHIFT: begin
                // move slot cmp_ptr down to cmp_ptr-1 while reading ahead
                n_ptr     = r_ptr + 1'b1;
                n_cmp_ptr = r_ptr;
                if (r_cmp_ptr < count_ext) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = shift_dst[IDX_W-1:0];
                    o_ram_wdata = i_ram_rdata;
                end else begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_cmp_ptr <= n_cmp_ptr;
        r_action  <= n_action;
        r_key     <= n_key;
        r_value   <= n_value;
        r_status  <= n_status;
        r_fval    <= n_fval;
        r_fidx    <= n_fidx;
    end

endmodule

FILE: design/unordered_key_value_table_core.sv
// Top level of the unordered key-value table: sequencer, entry RAM and output register.
//
//  channel  dir  handshake          payload
//  i_req    in   valid/ready        action, key, value
//  o_rsp    out  valid/ready        status, found_value, found_index, entry_count
//
// A lookup, an insert or a missed remove searches the stored entries in order; a remove that
// hits searches up to the key, then moves each later entry down one slot. The pace is set by
// the single RAM read port and the one key comparator, which visit one entry per cycle.
// Reset empties the table at once (count to zero, no clearing pass). A new request is taken
// while a result waits in the output register; the sequencer stalls only when a second
// result is ready.
module unordered_key_value_table_core import ukvt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ukvt_req_if.sink   i_req,
    ukvt_rsp_if.source o_rsp
);

    t_result          res;
    logic             res_valid;
    logic             res_ready;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_entry           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    t_entry           ram_rdata;
    logic [$bits(t_entry)-1:0] ram_rdata_raw;

    logic    r_out_valid;
    t_result r_out;

    ukvt_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    ukvt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_raw)
    );

    assign ram_rdata = t_entry'(ram_rdata_raw);

    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.found_value = r_out.found_value;
    assign o_rsp.found_index = OUT_IDX_W'(r_out.found_index);
    assign o_rsp.entry_count = OUT_CNT_W'(r_out.entry_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (res.entry_count <= CNT_W'(CAPACITY)))
        else $error("entry count above capacity");

    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res.status == STAT_FULL) |-> (res.entry_count == CNT_W'(CAPACITY)))
        else $error("full reported on a table with free slots");

    a_value_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res.status != STAT_OK) |-> (res.found_value == '0))
        else $error("value returned on a failed transaction");

    a_no_accept_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !i_req.ready)
        else $error("request taken while a result is pending in the sequencer");

endmodule
